// ===== src/ucs_pkg.sv =====
// UDP checksum engine package: item, queue entry and configuration types,
// register codes and the ones'-complement fold. Used by every other file in src.
`timescale 1ns / 1ps

package ucs_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] CSUM_WORD_POS = 3'd3;
    localparam logic [2:0] POS_MAX       = 3'd7;
    localparam logic [7:0] PROTO_RESET   = 8'd17;

    typedef enum logic [2:0] {
        REG_IP_VERSION = 3'd0,
        REG_PROTOCOL   = 3'd1,
        REG_ENABLE     = 3'd2,
        REG_SRC_HI     = 3'd3,
        REG_SRC_LO     = 3'd4,
        REG_DST_HI     = 3'd5,
        REG_DST_LO     = 3'd6
    } ucs_reg_t;

    typedef struct packed {
        logic        action;
        logic [15:0] data_word;
        logic [1:0]  bytes_valid;
        logic        last_word;
    } ucs_in_t;

    typedef struct packed {
        logic [15:0] checksum_value;
        logic        checksum_good;
        logic        check_skipped;
        logic [15:0] segment_length;
        logic        length_overflow;
        logic        last;
    } ucs_out_t;

    typedef struct packed {
        logic        mode;
        logic        field_zero;
        logic [15:0] sum;
        logic [15:0] length;
        logic        overflow;
    } ucs_entry_t;

    typedef struct packed {
        logic        ip_version;
        logic [7:0]  protocol_number;
        logic        checksum_enable;
        logic [15:0] src_hi_sum;
        logic [15:0] src_lo_sum;
        logic [15:0] dst_hi_sum;
        logic [15:0] dst_lo_sum;
        logic [15:0] src_v4_sum;
        logic [15:0] dst_v4_sum;
    } ucs_cfg_t;

    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] t;
        t = 17'(s[15:0]) + 17'(s[18:16]);
        return t[15:0] + 16'(t[16]);
    endfunction

    function automatic logic [15:0] oc_sum4(input logic [63:0] v);
        return oc_fold(19'(v[63:48]) + 19'(v[47:32]) + 19'(v[31:16]) + 19'(v[15:0]));
    endfunction

    function automatic logic [15:0] oc_sum2(input logic [31:0] v);
        return oc_fold(19'(v[31:16]) + 19'(v[15:0]));
    endfunction

endpackage

// ===== src/ucs_cfg_regs.sv =====
// Configuration registers on an APB-style port, with per-register word sums
// of the addresses kept for the pseudo-header. Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_cfg_regs
    import ucs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ucs_cfg_t          cfg
);

    logic        ip_version_reg;
    logic [7:0]  protocol_reg;
    logic        enable_reg;
    logic [63:0] src_hi_reg, src_lo_reg, dst_hi_reg, dst_lo_reg;
    logic [15:0] src_hi_sum_reg, src_lo_sum_reg, dst_hi_sum_reg, dst_lo_sum_reg;
    logic [15:0] src_v4_sum_reg, dst_v4_sum_reg;
    logic        wr_en;
    ucs_reg_t    index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = ucs_reg_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_version_reg <= 1'b0;
            protocol_reg   <= PROTO_RESET;
            enable_reg     <= 1'b0;
            src_hi_reg     <= '0;
            src_lo_reg     <= '0;
            dst_hi_reg     <= '0;
            dst_lo_reg     <= '0;
            src_hi_sum_reg <= '0;
            src_lo_sum_reg <= '0;
            dst_hi_sum_reg <= '0;
            dst_lo_sum_reg <= '0;
            src_v4_sum_reg <= '0;
            dst_v4_sum_reg <= '0;
        end else if (wr_en) begin
            unique case (index)
                REG_IP_VERSION: ip_version_reg <= pwdata[0];
                REG_PROTOCOL:   protocol_reg   <= pwdata[7:0];
                REG_ENABLE:     enable_reg     <= pwdata[0];
                REG_SRC_HI: begin
                    src_hi_reg     <= pwdata;
                    src_hi_sum_reg <= oc_sum4(pwdata);
                end
                REG_SRC_LO: begin
                    src_lo_reg     <= pwdata;
                    src_lo_sum_reg <= oc_sum4(pwdata);
                    src_v4_sum_reg <= oc_sum2(pwdata[31:0]);
                end
                REG_DST_HI: begin
                    dst_hi_reg     <= pwdata;
                    dst_hi_sum_reg <= oc_sum4(pwdata);
                end
                REG_DST_LO: begin
                    dst_lo_reg     <= pwdata;
                    dst_lo_sum_reg <= oc_sum4(pwdata);
                    dst_v4_sum_reg <= oc_sum2(pwdata[31:0]);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_IP_VERSION: prdata = 64'(ip_version_reg);
            REG_PROTOCOL:   prdata = 64'(protocol_reg);
            REG_ENABLE:     prdata = 64'(enable_reg);
            REG_SRC_HI:     prdata = src_hi_reg;
            REG_SRC_LO:     prdata = src_lo_reg;
            REG_DST_HI:     prdata = dst_hi_reg;
            REG_DST_LO:     prdata = dst_lo_reg;
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        cfg.ip_version      = ip_version_reg;
        cfg.protocol_number = protocol_reg;
        cfg.checksum_enable = enable_reg;
        cfg.src_hi_sum      = src_hi_sum_reg;
        cfg.src_lo_sum      = src_lo_sum_reg;
        cfg.dst_hi_sum      = dst_hi_sum_reg;
        cfg.dst_lo_sum      = dst_lo_sum_reg;
        cfg.src_v4_sum      = src_v4_sum_reg;
        cfg.dst_v4_sum      = dst_v4_sum_reg;
    end

endmodule

// ===== src/ucs_front.sv =====
// Front end: accepts segment words, masks and classifies them, keeps the
// running sum and byte count, and queues one entry per segment. Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_front
    import ucs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ucs_in_t    s_item,
    input  logic       q_full,
    output logic       q_push,
    output ucs_entry_t q_entry
);

    logic [15:0] sum_reg, sum_next;
    logic [15:0] count_reg, count_next;
    logic [2:0]  pos_reg, pos_next;
    logic        mode_reg, mode_next;
    logic        fz_reg, fz_next;
    logic        ovf_reg, ovf_next;
    logic [1:0]  nbytes;
    logic [15:0] word;
    logic [16:0] total;
    logic        fire;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;
    assign q_push  = fire && s_item.last_word;

    always_comb begin
        nbytes = (s_item.bytes_valid == 2'd3) ? 2'd2 : s_item.bytes_valid;
        case (nbytes)
            2'd0:    word = 16'h0000;
            2'd1:    word = {s_item.data_word[15:8], 8'h00};
            default: word = s_item.data_word;
        endcase
        mode_next = (pos_reg == 3'd0) ? s_item.action : mode_reg;
        fz_next   = fz_reg;
        if (pos_reg == CSUM_WORD_POS) begin
            fz_next = (word == 16'h0000);
            if (!mode_next) begin
                word = 16'h0000;
            end
        end
        sum_next = oc_fold(19'(sum_reg) + 19'(word));
        total    = 17'(count_reg) + 17'(nbytes);
        if (total[16]) begin
            count_next = 16'hffff;
            ovf_next   = 1'b1;
        end else begin
            count_next = total[15:0];
            ovf_next   = ovf_reg;
        end
        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 3'd1;

        q_entry.mode       = mode_next;
        q_entry.field_zero = fz_next;
        q_entry.sum        = sum_next;
        q_entry.length     = count_next;
        q_entry.overflow   = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            mode_reg  <= 1'b0;
            fz_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (fire) begin
            if (s_item.last_word) begin
                sum_reg   <= '0;
                count_reg <= '0;
                pos_reg   <= '0;
                mode_reg  <= 1'b0;
                fz_reg    <= 1'b0;
                ovf_reg   <= 1'b0;
            end else begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                pos_reg   <= pos_next;
                mode_reg  <= mode_next;
                fz_reg    <= fz_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> (pos_reg == 3'd0) && (count_reg == 16'h0000) && !ovf_reg)
        else $error("segment state not cleared after last word");

endmodule

// ===== src/ucs_queue.sv =====
// Short queue of per-segment entries between front and back ends.
// Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_queue
    import ucs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ucs_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output ucs_entry_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ucs_entry_t    mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

// ===== src/ucs_back.sv =====
// Back end: folds the pseudo-header into a queued segment sum, forms the
// result and holds it in the output register. Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_back
    import ucs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ucs_cfg_t   cfg,
    input  logic       q_not_empty,
    input  ucs_entry_t q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output ucs_out_t   m_item
);

    logic        m_valid_reg, m_valid_next;
    ucs_out_t    m_item_reg, m_item_next;
    logic [18:0] total;
    logic [15:0] full_sum;
    logic [15:0] inv_sum;

    assign q_pop   = q_not_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        if (cfg.ip_version) begin
            total = 19'(q_head.sum) + 19'(q_head.length) + 19'(cfg.protocol_number)
                  + 19'(cfg.src_hi_sum) + 19'(cfg.src_lo_sum)
                  + 19'(cfg.dst_hi_sum) + 19'(cfg.dst_lo_sum);
        end else begin
            total = 19'(q_head.sum) + 19'(q_head.length) + 19'(cfg.protocol_number)
                  + 19'(cfg.src_v4_sum) + 19'(cfg.dst_v4_sum);
        end
        full_sum = oc_fold(total);
        inv_sum  = ~full_sum;

        m_item_next.checksum_value  = 16'h0000;
        m_item_next.checksum_good   = 1'b0;
        m_item_next.check_skipped   = 1'b0;
        m_item_next.segment_length  = q_head.length;
        m_item_next.length_overflow = q_head.overflow;
        m_item_next.last            = 1'b1;
        if (!cfg.checksum_enable) begin
            m_item_next.check_skipped = 1'b1;
            m_item_next.checksum_good = q_head.mode;
        end else if (!q_head.mode) begin
            m_item_next.checksum_value = (inv_sum == 16'h0000) ? 16'hffff : inv_sum;
        end else if (q_head.field_zero) begin
            m_item_next.check_skipped = 1'b1;
            m_item_next.checksum_good = 1'b1;
        end else begin
            m_item_next.checksum_good = (inv_sum == 16'h0000);
        end

        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_item_reg <= m_item_next;
        end
    end

    a_pop_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid_reg && m_item_reg.last)
        else $error("popped entry did not reach the output register");

endmodule

// ===== src/udp_checksum_engine.sv =====
// UDP checksum engine top level: one 16-bit segment word per cycle, one
// result per segment on m_valid, passed from the queue through the output register.
// Sustains one word per cycle while s_ready is high; the queue depth sets how
// many finished segments may wait on a stalled result channel before s_ready drops.
// Synchronous active-low reset clears segment state, queue and output valid,
// and loads register defaults (IPv4, protocol 17, checksum disabled).
`timescale 1ns / 1ps

module udp_checksum_engine
    import ucs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ucs_in_t           s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output ucs_out_t          m_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    ucs_cfg_t   cfg;
    ucs_entry_t push_entry;
    ucs_entry_t head;
    logic       push;
    logic       pop;
    logic       full;
    logic       not_empty;

    ucs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ucs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (full),
        .q_push  (push),
        .q_entry (push_entry)
    );

    ucs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    ucs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_not_empty (not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

// ===== test/tb_udp_checksum_engine.sv =====
`timescale 1ns / 1ps
// Testbench for udp_checksum_engine: directed and random UDP segments over the item
// channels, register setup over APB, every result checked against an in-bench predictor.
// Depends only on ucs_pkg and the engine RTL.

module tb_udp_checksum_engine;
    import ucs_pkg::*;

    localparam logic ACT_GENERATE = 1'b0;
    localparam logic ACT_VERIFY   = 1'b1;

    typedef struct packed {
        logic [15:0] sum;
        logic [15:0] count;
        logic [2:0]  pos;
        logic        mode;
        logic        field_zero;
        logic        ovf;
    } seg_state_t;

    typedef struct packed {
        logic        ip_v6;
        logic [7:0]  proto;
        logic        enable;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
    } csum_cfg_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ucs_in_t           s_item  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ucs_out_t          m_item;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    csum_cfg_t  cfg_shadow;
    seg_state_t stream_state;
    ucs_out_t   pending_results[$];
    ucs_in_t    seg_words[$];
    bit         idle_on = 1'b1;
    int         idle_pct = 0;
    int         stall_left = 0;
    int         words_sent = 0;
    int         segs_sent = 0;
    int         results_checked = 0;
    int         mismatches = 0;

    udp_checksum_engine u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + 16'(s[16]);
    endfunction

    function automatic logic [15:0] add_quad(input logic [15:0] s, input logic [63:0] v);
        s = oc_add16(s, v[63:48]);
        s = oc_add16(s, v[47:32]);
        s = oc_add16(s, v[31:16]);
        return oc_add16(s, v[15:0]);
    endfunction

    function automatic logic [15:0] pseudo_hdr_sum(input logic [15:0] len);
        logic [15:0] s;
        s = 16'h0000;
        if (!cfg_shadow.ip_v6) begin
            s = oc_add16(s, cfg_shadow.src_lo[31:16]);
            s = oc_add16(s, cfg_shadow.src_lo[15:0]);
            s = oc_add16(s, cfg_shadow.dst_lo[31:16]);
            s = oc_add16(s, cfg_shadow.dst_lo[15:0]);
        end else begin
            s = add_quad(s, cfg_shadow.src_hi);
            s = add_quad(s, cfg_shadow.src_lo);
            s = add_quad(s, cfg_shadow.dst_hi);
            s = add_quad(s, cfg_shadow.dst_lo);
        end
        s = oc_add16(s, {8'h00, cfg_shadow.proto});
        return oc_add16(s, len);
    endfunction

    function automatic seg_state_t seg_advance(input seg_state_t st, input ucs_in_t it);
        logic [15:0] w;
        logic [1:0]  nb;
        logic [16:0] total;
        nb = (it.bytes_valid == 2'd3) ? 2'd2 : it.bytes_valid;
        w = it.data_word;
        if (nb == 2'd1) w[7:0] = 8'h00;
        else if (nb == 2'd0) w = 16'h0000;
        if (st.pos == 3'd0) st.mode = it.action;
        if (st.pos == 3'd3) begin
            st.field_zero = (w == 16'h0000);
            if (st.mode == ACT_GENERATE) w = 16'h0000;
        end
        st.sum = oc_add16(st.sum, w);
        total = {1'b0, st.count} + 17'(nb);
        if (total[16]) begin
            st.count = 16'hffff;
            st.ovf = 1'b1;
        end else begin
            st.count = total[15:0];
        end
        if (st.pos != 3'd7) st.pos = st.pos + 3'd1;
        return st;
    endfunction

    function automatic logic [15:0] seg_total(input seg_state_t st);
        return oc_add16(st.sum, pseudo_hdr_sum(st.count));
    endfunction

    function automatic ucs_out_t seg_result(input seg_state_t st);
        ucs_out_t r;
        logic [15:0] sum;
        sum = seg_total(st);
        r = '0;
        r.segment_length  = st.count;
        r.length_overflow = st.ovf;
        r.last            = 1'b1;
        if (!cfg_shadow.enable) begin
            r.check_skipped = 1'b1;
            r.checksum_good = st.mode;
        end else if (st.mode == ACT_GENERATE) begin
            r.checksum_value = (sum == 16'hffff) ? 16'hffff : ~sum;
        end else if (st.field_zero) begin
            r.check_skipped = 1'b1;
            r.checksum_good = 1'b1;
        end else begin
            r.checksum_good = (sum == 16'hffff);
        end
        return r;
    endfunction

    // checksum the staged segment would get in generate mode
    function automatic logic [15:0] seg_checksum();
        seg_state_t st;
        ucs_in_t    it;
        logic [15:0] c;
        st = '0;
        foreach (seg_words[i]) begin
            it = seg_words[i];
            if (i == 0) it.action = ACT_GENERATE;
            st = seg_advance(st, it);
        end
        c = ~seg_total(st);
        return (c == 16'h0000) ? 16'hffff : c;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    always @(posedge aclk) begin : result_check
        ucs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got value=%h good=%b skip=%b",
                         $time, m_item.checksum_value, m_item.checksum_good,
                         m_item.check_skipped);
                $display("%0t:   len=%0d ovf=%b last=%b",
                         $time, m_item.segment_length, m_item.length_overflow, m_item.last);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_item !== want) begin
                    mismatches++;
                    $display("%0t: expected value=%h good=%b skip=%b len=%0d ovf=%b last=%b",
                             $time, want.checksum_value, want.checksum_good,
                             want.check_skipped, want.segment_length,
                             want.length_overflow, want.last);
                    $display("%0t:   actual value=%h good=%b skip=%b len=%0d ovf=%b last=%b",
                             $time, m_item.checksum_value, m_item.checksum_good,
                             m_item.check_skipped, m_item.segment_length,
                             m_item.length_overflow, m_item.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 99) < 6) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 18);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic cfg_write(input ucs_reg_t r, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (r)
            REG_IP_VERSION: cfg_shadow.ip_v6  = v[0];
            REG_PROTOCOL:   cfg_shadow.proto  = v[7:0];
            REG_ENABLE:     cfg_shadow.enable = v[0];
            REG_SRC_HI:     cfg_shadow.src_hi = v;
            REG_SRC_LO:     cfg_shadow.src_lo = v;
            REG_DST_HI:     cfg_shadow.dst_hi = v;
            REG_DST_LO:     cfg_shadow.dst_lo = v;
            default: ;
        endcase
    endtask

    task automatic cfg_load(input logic ip, input logic [7:0] proto, input logic en,
                            input logic [63:0] shi, input logic [63:0] slo,
                            input logic [63:0] dhi, input logic [63:0] dlo);
        cfg_write(REG_IP_VERSION, 64'(ip));
        cfg_write(REG_PROTOCOL, 64'(proto));
        cfg_write(REG_ENABLE, 64'(en));
        cfg_write(REG_SRC_HI, shi);
        cfg_write(REG_SRC_LO, slo);
        cfg_write(REG_DST_HI, dhi);
        cfg_write(REG_DST_LO, dlo);
    endtask

    task automatic add_word(input logic act, input logic [15:0] data, input logic [1:0] bv,
                            input logic fin);
        ucs_in_t w;
        w.action      = act;
        w.data_word   = data;
        w.bytes_valid = bv;
        w.last_word   = fin;
        seg_words.push_back(w);
    endtask

    task automatic send_word(input ucs_in_t it);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        stream_state = seg_advance(stream_state, it);
        if (it.last_word) begin
            pending_results.push_back(seg_result(stream_state));
            stream_state = '0;
        end
    endtask

    task automatic send_segment();
        idle_pct = (!idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        foreach (seg_words[i]) send_word(seg_words[i]);
        seg_words.delete();
        segs_sent++;
    endtask

    // drop valid, let all results drain, then allow for the output pipeline
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic build_random_segment();
        int n;
        int kind;
        int k;
        seg_words.delete();
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 64) : $urandom_range(4, 14);
            for (int i = 0; i < n; i++)
                add_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), 2'd2,
                         i == n - 1);
            if ($urandom_range(0, 1) == 1) seg_words[n-1].bytes_valid = 2'd1;
            if (seg_words[0].action == ACT_VERIFY) begin
                case ($urandom_range(0, 9))
                    0: seg_words[3].data_word = 16'h0000;
                    1: begin
                        seg_words[3].data_word = seg_checksum();
                        k = $urandom_range(0, n - 1);
                        seg_words[k].data_word = seg_words[k].data_word
                                                 ^ (16'h0001 << $urandom_range(0, 15));
                    end
                    default: seg_words[3].data_word = seg_checksum();
                endcase
            end
        end else if (kind < 16) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                add_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                         2'($urandom_range(1, 2)), i == n - 1);
        end else begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
                add_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                         2'($urandom_range(0, 3)), i == n - 1);
        end
    endtask

    task automatic test_reset_defaults();
        add_word(ACT_GENERATE, 16'hffff, 2'd2, 1'b0);
        add_word(ACT_VERIFY,   16'h0000, 2'd2, 1'b0);
        add_word(ACT_VERIFY,   16'h7ffe, 2'd2, 1'b0);
        add_word(ACT_GENERATE, 16'habcd, 2'd1, 1'b1);
        send_segment();
        add_word(ACT_VERIFY, 16'hffff, 2'd2, 1'b1);
        send_segment();
        finish_phase();
    endtask

    task automatic test_register_widths();
        cfg_write(REG_IP_VERSION, 64'hffff_ffff_ffff_fffe);
        cfg_write(REG_PROTOCOL,   64'hffff_ffff_ffff_ff06);
        cfg_write(REG_ENABLE,     64'h8000_0001_0000_0003);
        cfg_write(REG_SRC_HI,     rnd64());
        cfg_write(REG_SRC_LO,     64'hdead_beef_c0a8_0001);
        cfg_write(REG_DST_HI,     rnd64());
        cfg_write(REG_DST_LO,     64'h0123_4567_0a00_0002);
        add_word(ACT_GENERATE, 16'h1111, 2'd2, 1'b0);
        add_word(ACT_VERIFY,   16'h2222, 2'd0, 1'b0);
        add_word(ACT_GENERATE, 16'h3333, 2'd3, 1'b0);
        add_word(ACT_VERIFY,   16'h4444, 2'd2, 1'b1);
        send_segment();
        finish_phase();
    endtask

    // segment whose generated checksum folds to zero and must go out as all ones
    task automatic test_generate_cases();
        cfg_write(REG_PROTOCOL, 64'd17);
        for (int i = 0; i < 4; i++)
            add_word(ACT_GENERATE, 16'($urandom_range(0, 65535)), 2'd2, 1'b0);
        add_word(ACT_VERIFY, 16'h0000, 2'd2, 1'b1);
        seg_words[4].data_word = seg_checksum();
        send_segment();
        finish_phase();
    endtask

    task automatic test_verify_cases();
        cfg_write(REG_IP_VERSION, 64'd1);
        for (int i = 0; i < 5; i++)
            add_word(ACT_VERIFY, 16'($urandom_range(0, 65535)), (i == 4) ? 2'd1 : 2'd2, i == 4);
        seg_words[3].data_word = seg_checksum();
        send_segment();
        for (int i = 0; i < 4; i++)
            add_word(ACT_VERIFY, (i == 3) ? 16'h0000 : 16'($urandom_range(0, 65535)), 2'd2,
                     i == 3);
        send_segment();
        add_word(ACT_VERIFY, 16'h0011, 2'd2, 1'b0);
        add_word(ACT_GENERATE, 16'hff00, 2'd2, 1'b1);
        send_segment();
        finish_phase();
    endtask

    task automatic random_traffic(input int n_items);
        int first;
        first = words_sent;
        while (words_sent - first < n_items) begin
            build_random_segment();
            send_segment();
        end
        finish_phase();
    endtask

    task automatic test_random_configs();
        cfg_load(1'b0, 8'd17, 1'b1, rnd64(), rnd64(), rnd64(), rnd64());
        random_traffic(250);
        cfg_load(1'b1, 8'($urandom_range(0, 255)), 1'b1, rnd64(), rnd64(), rnd64(), rnd64());
        random_traffic(250);
        cfg_load(1'b1, 8'hff, 1'b1, '1, '1, '1, '1);
        random_traffic(250);
        cfg_load(1'b0, 8'h00, 1'b1, '0, '0, '0, '0);
        random_traffic(250);
        cfg_load(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0,
                 rnd64(), rnd64(), rnd64(), rnd64());
        random_traffic(250);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        cfg_load(1'b1, 8'd17, 1'b1, rnd64(), rnd64(), rnd64(), rnd64());
        random_traffic(200);
    endtask

    initial begin
        cfg_shadow       = '0;
        cfg_shadow.proto = PROTO_RESET;
        stream_state     = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_register_widths();
        test_generate_cases();
        test_verify_cases();
        test_random_configs();
        test_back_to_back();
        $display("Covered %0d words in %0d segments, %0d results checked, %0d mismatches.",
                 words_sent, segs_sent, results_checked, mismatches);
        $display("Ran IPv4 and IPv6, generate and verify, checks on and off, odd and empty words.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[udp_checksum_engine] OK");
        end else begin
            $display("[udp_checksum_engine] ERROR");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("[udp_checksum_engine] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ucs_pkg.sv
src/ucs_cfg_regs.sv
src/ucs_front.sv
src/ucs_queue.sv
src/ucs_back.sv
src/udp_checksum_engine.sv
test/tb_udp_checksum_engine.sv
